>>> hdl/pspo_pkg.sv
// shared types and constants of the point set orientation block
`default_nettype none

package pspo_pkg;

    localparam int MaxPoints = 1024;
    localparam int MinPoints = 5;
    localparam int CntW = 11;
    localparam int SumW = 26;
    localparam int SqW = 42;

    localparam int DivNW = 52;
    localparam int DivDW = 21;
    localparam int SqrtW = 64;
    localparam int RootW = 32;

    localparam logic [1:0] StatOk = 2'd0;
    localparam logic [1:0] StatFew = 2'd1;
    localparam logic [1:0] StatOvf = 2'd2;

    localparam logic [1:0] RangeWrap360 = 2'd0;
    localparam logic [1:0] RangeWrapSym = 2'd1;
    localparam logic [1:0] RangeWrap180 = 2'd2;
    localparam logic [1:0] RangeRaw = 2'd3;

    localparam logic signed [16:0] Ang360 = 17'sd23040;
    localparam logic signed [16:0] Ang180 = 17'sd11520;
    localparam logic signed [21:0] Z90 = 22'sd368640;

    localparam logic [17:0] AtanTab [16] = '{
        18'd184320, 18'd108810, 18'd57492, 18'd29184, 18'd14649, 18'd7331, 18'd3667, 18'd1833,
        18'd917, 18'd458, 18'd229, 18'd115, 18'd57, 18'd29, 18'd14, 18'd7
    };

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic signed [15:0] angle_deg;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        major_length;
        logic [15:0]        minor_length;
        logic [10:0]        point_count;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic [CntW-1:0]        count;
        logic signed [SumW-1:0] sum_x;
        logic signed [SumW-1:0] sum_y;
        logic signed [SqW-1:0]  sum_xx;
        logic signed [SqW-1:0]  sum_yy;
        logic signed [SqW-1:0]  sum_xy;
        logic                   overflow;
    } sums_t;

endpackage

`default_nettype wire

>>> hdl/pspo_front.sv
// point accumulator: count, first and second order sums
`default_nettype none

module pspo_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  pspo_pkg::point_t point,
    output logic             push,
    output pspo_pkg::sums_t  sums
);
    import pspo_pkg::*;

    logic [CntW-1:0]        count_reg;
    logic signed [SumW-1:0] sum_x_reg, sum_y_reg;
    logic signed [SqW-1:0]  sum_xx_reg, sum_yy_reg, sum_xy_reg;
    logic                   overflow_reg;
    logic signed [31:0]     xx, yy, xy;
    logic                   room;

    assign xx = point.point_x * point.point_x;
    assign yy = point.point_y * point.point_y;
    assign xy = point.point_x * point.point_y;
    assign room = count_reg < CntW'(MaxPoints);

    always_comb
    begin
        sums.count = room ? count_reg + CntW'(1) : count_reg;
        sums.sum_x = room ? sum_x_reg + SumW'(point.point_x) : sum_x_reg;
        sums.sum_y = room ? sum_y_reg + SumW'(point.point_y) : sum_y_reg;
        sums.sum_xx = room ? sum_xx_reg + SqW'(xx) : sum_xx_reg;
        sums.sum_yy = room ? sum_yy_reg + SqW'(yy) : sum_yy_reg;
        sums.sum_xy = room ? sum_xy_reg + SqW'(xy) : sum_xy_reg;
        sums.overflow = overflow_reg | ~room;
    end

    assign push = take & point.last_point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else if (take)
        begin
            if (point.last_point)
            begin
                count_reg <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_xx_reg <= '0;
                sum_yy_reg <= '0;
                sum_xy_reg <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                count_reg <= sums.count;
                sum_x_reg <= sums.sum_x;
                sum_y_reg <= sums.sum_y;
                sum_xx_reg <= sums.sum_xx;
                sum_yy_reg <= sums.sum_yy;
                sum_xy_reg <= sums.sum_xy;
                overflow_reg <= sums.overflow;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/pspo_fifo.sv
// two-entry queue of finished point sets
`default_nettype none

module pspo_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pspo_pkg::sums_t din,
    input  logic            pop,
    output pspo_pkg::sums_t dout,
    output logic            full,
    output logic            empty
);
    import pspo_pkg::*;

    sums_t      mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout = mem[rd_ptr_reg];
    assign full = fill_reg == 2'd2;
    assign empty = fill_reg == 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/pspo_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module pspo_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pspo_pkg::DivNW-1:0] dividend,
    input  logic [pspo_pkg::DivDW-1:0] divisor,
    output logic                       done,
    output logic [pspo_pkg::DivNW-1:0] quotient
);
    import pspo_pkg::*;

    localparam int CW = $clog2(DivNW + 1);

    logic [DivNW-1:0] quo_reg;
    logic [DivDW-1:0] rem_reg, dsr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg, done_reg;
    logic [DivDW:0]   shifted, diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DivNW-1]};
    assign diff = shifted - {1'b0, dsr_reg};
    assign fits = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DivNW-2:0], fits};
            rem_reg <= fits ? diff[DivDW-1:0] : shifted[DivDW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && !start && cnt_reg == CW'(1);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DivNW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/pspo_sqrt.sv
// integer square root, two radicand bits per cycle, with remainder
`default_nettype none

module pspo_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pspo_pkg::SqrtW-1:0] value,
    output logic                       done,
    output logic [pspo_pkg::RootW-1:0] root,
    output logic [pspo_pkg::RootW:0]   rem
);
    import pspo_pkg::*;

    localparam int CW = $clog2(RootW + 1);

    logic [SqrtW-1:0] v_reg, r_reg, bit_reg, trial;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg, done_reg;
    logic             ge;

    assign trial = r_reg + bit_reg;
    assign ge = v_reg >= trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            r_reg <= '0;
            bit_reg <= {2'b01, {(SqrtW - 2){1'b0}}};
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && !start && cnt_reg == CW'(1);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(RootW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[RootW-1:0];
    assign rem = v_reg[RootW:0];

endmodule

`default_nettype wire

>>> hdl/pspo_back.sv
// per-set evaluation: centroid, covariance, eigen lengths, cordic angle, wrap
`default_nettype none

module pspo_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  pspo_pkg::sums_t   head,
    output logic              pop,
    input  logic [1:0]        angle_range,
    output logic              done,
    output pspo_pkg::result_t result
);
    import pspo_pkg::*;

    typedef enum logic [10:0] {
        StIdle    = 11'b00000000001,
        StLoad    = 11'b00000000010,
        StMul     = 11'b00000000100,
        StDivGo   = 11'b00000001000,
        StDivWait = 11'b00000010000,
        StSqMul   = 11'b00000100000,
        StSqGo    = 11'b00001000000,
        StSqWait  = 11'b00010000000,
        StCord    = 11'b00100000000,
        StWrap    = 11'b01000000000,
        StOut     = 11'b10000000000
    } state_t;

    localparam logic [2:0] JobCx = 3'd0;
    localparam logic [2:0] JobCy = 3'd1;
    localparam logic [2:0] JobCxx = 3'd2;
    localparam logic [2:0] JobCyy = 3'd3;
    localparam logic [2:0] JobCxy = 3'd4;
    localparam logic [1:0] SqR = 2'd0;
    localparam logic [1:0] SqMaj = 2'd1;
    localparam logic [1:0] SqMin = 2'd2;

    state_t state_reg, state_next;
    logic [2:0] job_reg;
    logic [1:0] sq_job_reg;
    logic [3:0] it_reg;

    sums_t                  ent_reg;
    logic [20:0]            n2_reg;
    logic signed [53:0]     p1_reg;
    logic signed [51:0]     p2_reg;
    logic                   neg_reg;
    logic signed [15:0]     cx_reg, cy_reg;
    logic signed [31:0]     cxx_reg, cyy_reg, cxy_reg;
    logic [63:0]            dd_reg, cc_reg;
    logic [31:0]            r_reg;
    logic [15:0]            major_reg, minor_reg;
    logic signed [35:0]     x_reg, y_reg;
    logic signed [21:0]     z_reg;
    result_t                res_reg;

    logic [CntW-1:0]        n;
    logic                   few;
    logic signed [SumW-1:0] sa, sb, cen_s;
    logic signed [SqW-1:0]  sab;
    logic                   cen_neg, w_neg, is_cen;
    logic [SumW-1:0]        cen_mag;
    logic signed [53:0]     w;
    logic [53:0]            w_mag;
    logic [DivNW-1:0]       div_dividend, div_quo;
    logic [DivDW-1:0]       div_divisor;
    logic                   div_done, sqrt_done;
    logic [SqrtW-1:0]       sq_in;
    logic [RootW-1:0]       sq_root;
    logic [RootW:0]         sq_rem, rnd;
    logic [15:0]            rnd_sat;
    logic signed [31:0]     d;
    logic [32:0]            t;
    logic [33:0]            tr_sum;
    logic signed [33:0]     yv;
    logic signed [35:0]     xv, dx, dy;
    logic signed [21:0]     at, zr;
    logic signed [16:0]     ang, base, modv, wrapped, ang_out;

    assign n = ent_reg.count;
    assign few = n < CntW'(MinPoints);
    assign is_cen = job_reg == JobCx || job_reg == JobCy;

    always_comb
    begin
        sa = ent_reg.sum_x;
        sb = ent_reg.sum_y;
        sab = ent_reg.sum_xy;
        if (job_reg == JobCxx)
        begin
            sb = ent_reg.sum_x;
            sab = ent_reg.sum_xx;
        end
        else if (job_reg == JobCyy)
        begin
            sa = ent_reg.sum_y;
            sab = ent_reg.sum_yy;
        end
    end

    assign cen_s = (job_reg == JobCy) ? ent_reg.sum_y : ent_reg.sum_x;
    assign cen_neg = cen_s[SumW-1];
    assign cen_mag = cen_neg ? SumW'(-cen_s) : SumW'(cen_s);
    assign w = p1_reg - 54'(p2_reg);
    assign w_neg = w[53];
    assign w_mag = w_neg ? 54'(-w) : 54'(w);

    assign div_dividend = is_cen ? DivNW'({cen_mag, 1'b0}) + DivNW'(n) : w_mag[DivNW-1:0];
    assign div_divisor = is_cen ? DivDW'({n, 1'b0}) : n2_reg;

    pspo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == StDivGo),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign d = cxx_reg - cyy_reg;
    assign t = 33'(cxx_reg) + 33'(cyy_reg);
    assign tr_sum = 34'(t) + 34'(r_reg);

    always_comb
    begin
        sq_in = '0;
        if (sq_job_reg == SqR)
        begin
            sq_in = dd_reg + {cc_reg[61:0], 2'b00};
        end
        else if (sq_job_reg == SqMaj)
        begin
            sq_in = SqrtW'({tr_sum, 1'b0});
        end
        else if (t > 33'(r_reg))
        begin
            sq_in = SqrtW'({t - 33'(r_reg), 1'b0});
        end
    end

    pspo_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == StSqGo),
        .value (sq_in),
        .done  (sqrt_done),
        .root  (sq_root),
        .rem   (sq_rem)
    );

    assign rnd = 33'(sq_root) + 33'(sq_rem > 33'(sq_root));
    assign rnd_sat = (rnd > 33'd65535) ? 16'hFFFF : rnd[15:0];

    assign yv = $signed({2'b00, r_reg}) - 34'(d);
    assign xv = 36'(cxy_reg) <<< 1;
    assign dx = y_reg >>> it_reg;
    assign dy = x_reg >>> it_reg;
    assign at = $signed({4'b0000, AtanTab[it_reg]});

    assign zr = (z_reg + 22'sd32) >>> 6;
    assign ang = $signed(zr[16:0]);
    assign base = (angle_range == RangeWrapSym) ? ang + Ang180 : ang;
    assign modv = (angle_range == RangeWrap180) ? Ang180 : Ang360;

    always_comb
    begin
        if (base < 17'sd0)
        begin
            wrapped = base + modv;
        end
        else if (base >= modv)
        begin
            wrapped = base - modv;
        end
        else
        begin
            wrapped = base;
        end
        unique case (angle_range)
            RangeWrapSym: ang_out = wrapped - Ang180;
            RangeRaw:     ang_out = ang;
            default:      ang_out = wrapped;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            StIdle:    if (!empty) state_next = StLoad;
            StLoad:    state_next = few ? StOut : StMul;
            StMul:     state_next = StDivGo;
            StDivGo:   state_next = StDivWait;
            StDivWait:
            begin
                if (div_done)
                begin
                    state_next = (job_reg == JobCxy) ? StSqMul : StMul;
                end
            end
            StSqMul:   state_next = StSqGo;
            StSqGo:    state_next = StSqWait;
            StSqWait:
            begin
                if (sqrt_done)
                begin
                    if (sq_job_reg == SqMin)
                    begin
                        state_next = (cxy_reg != 32'sd0) ? StCord : StWrap;
                    end
                    else
                    begin
                        state_next = StSqGo;
                    end
                end
            end
            StCord:    if (it_reg == 4'd15) state_next = StWrap;
            StWrap:    state_next = StOut;
            StOut:     state_next = StIdle;
            default:   state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            job_reg <= JobCx;
            sq_job_reg <= SqR;
            it_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == StLoad)
            begin
                job_reg <= JobCx;
            end
            else if (state_reg == StDivWait && div_done)
            begin
                job_reg <= job_reg + 3'd1;
            end
            if (state_reg == StSqMul)
            begin
                sq_job_reg <= SqR;
            end
            else if (state_reg == StSqWait && sqrt_done)
            begin
                sq_job_reg <= sq_job_reg + 2'd1;
            end
            if (state_reg == StCord)
            begin
                it_reg <= it_reg + 4'd1;
            end
            else
            begin
                it_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            StIdle:
            begin
                if (!empty)
                begin
                    ent_reg <= head;
                end
            end
            StLoad:
            begin
                n2_reg <= n * n;
                if (few)
                begin
                    res_reg.angle_deg <= '0;
                    res_reg.center_x <= '0;
                    res_reg.center_y <= '0;
                    res_reg.major_length <= '0;
                    res_reg.minor_length <= '0;
                    res_reg.point_count <= n;
                    res_reg.status <= StatFew;
                end
            end
            StMul:
            begin
                p1_reg <= $signed({1'b0, n}) * sab;
                p2_reg <= sa * sb;
            end
            StDivGo:
            begin
                neg_reg <= is_cen ? cen_neg : w_neg;
            end
            StDivWait:
            begin
                if (div_done)
                begin
                    unique case (job_reg)
                        JobCx:  cx_reg <= neg_reg ? -div_quo[15:0] : div_quo[15:0];
                        JobCy:  cy_reg <= neg_reg ? -div_quo[15:0] : div_quo[15:0];
                        JobCxx: cxx_reg <= neg_reg ? 32'sd0 : $signed(div_quo[31:0]);
                        JobCyy: cyy_reg <= neg_reg ? 32'sd0 : $signed(div_quo[31:0]);
                        default: cxy_reg <= neg_reg ? -$signed(div_quo[31:0])
                                                    : $signed(div_quo[31:0]);
                    endcase
                end
            end
            StSqMul:
            begin
                dd_reg <= d * d;
                cc_reg <= cxy_reg * cxy_reg;
            end
            StSqWait:
            begin
                if (sqrt_done)
                begin
                    unique case (sq_job_reg)
                        SqR:     r_reg <= sq_root;
                        SqMaj:   major_reg <= rnd_sat;
                        default:
                        begin
                            minor_reg <= rnd_sat;
                            if (cxy_reg == 32'sd0)
                            begin
                                z_reg <= (cxx_reg >= cyy_reg) ? 22'sd0 : Z90;
                            end
                            else if (xv < 36'sd0)
                            begin
                                x_reg <= 36'(yv);
                                y_reg <= -xv;
                                z_reg <= Z90;
                            end
                            else
                            begin
                                x_reg <= xv;
                                y_reg <= 36'(yv);
                                z_reg <= 22'sd0;
                            end
                        end
                    endcase
                end
            end
            StCord:
            begin
                if (y_reg > 36'sd0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
            end
            StWrap:
            begin
                res_reg.angle_deg <= ang_out[15:0];
                res_reg.center_x <= cx_reg;
                res_reg.center_y <= cy_reg;
                res_reg.major_length <= major_reg;
                res_reg.minor_length <= minor_reg;
                res_reg.point_count <= n;
                res_reg.status <= ent_reg.overflow ? StatOvf : StatOk;
            end
            default:
            begin
            end
        endcase
    end

    assign pop = (state_reg == StIdle) && !empty;
    assign done = state_reg == StOut;
    assign result = res_reg;

endmodule

`default_nettype wire

>>> hdl/point_set_pca_orientation_top.sv
// top level of the point set principal-axis orientation block
//
// points enter on start/busy: a point transfers at a clock edge with start high
// and busy low; last_point closes the set. the accumulator takes one point per
// cycle while busy is low.
// a closed set goes into a two-entry queue; busy rises only while that queue is
// full. the evaluator drains the queue one set at a time.
// a set of five or more points, once it leaves the queue, runs five divisions
// (centroid, covariance), three square roots and, unless the xy covariance is
// zero, 16 cordic steps, one after another, before its result shows.
// a set of fewer than five points goes from the load state straight to the
// output state and skips the arithmetic.
// each result shows on result for one cycle with done high; the receiver
// takes it then and cannot hold it off.
// angle_range is at apb address 0; written between sets by the user, unchecked.
// reset clears the sums, the queue, the evaluator and angle_range.
`default_nettype none

module point_set_pca_orientation_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pspo_pkg::point_t  point,
    output logic              done,
    output pspo_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pspo_pkg::*;

    localparam logic RegAngleRange = 1'b0;

    logic [1:0] angle_range_reg;
    logic       take, push, pop, full, empty;
    sums_t      set_sums, head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegAngleRange) ? 32'(angle_range_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_range_reg <= RangeWrap360;
        end
        else if (psel && penable && pwrite && paddr[2] == RegAngleRange)
        begin
            angle_range_reg <= pwdata[1:0];
        end
    end

    assign busy = full;
    assign take = start && !busy;

    pspo_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .point (point),
        .push  (push),
        .sums  (set_sums)
    );

    pspo_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (set_sums),
        .pop   (pop),
        .dout  (head),
        .full  (full),
        .empty (empty)
    );

    pspo_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .angle_range (angle_range_reg),
        .done        (done),
        .result      (result)
    );

endmodule

`default_nettype wire

>>> hdl/pspo_checker.sv
// port-level assertions for the orientation block and their bind
`default_nettype none

module pspo_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              done,
    input pspo_pkg::result_t result
);
    import pspo_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == StatOk || result.status == StatFew
                  || result.status == StatOvf))
        else $error("bad status code");

    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == StatFew |-> result.point_count < 11'd5
            && result.angle_deg == 16'sd0 && result.center_x == 16'sd0
            && result.center_y == 16'sd0 && result.major_length == 16'd0
            && result.minor_length == 16'd0)
        else $error("short set result not cleared");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != StatFew |-> result.point_count >= 11'd5)
        else $error("short set without short status");

    a_axis_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.major_length >= result.minor_length)
        else $error("minor axis longer than major axis");

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

endmodule

bind point_set_pca_orientation_top pspo_checker u_pspo_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);

`default_nettype wire
